### design/hsv2rgb_pkg.sv
// shared types, constants and helpers for the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

  localparam int CH_W = 8;
  localparam int Y_W = 14;
  localparam int RECIP_SHIFT = 21;
  localparam logic [15:0] RECIP_60 = 16'd34953;

  typedef logic [CH_W-1:0] chan_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5,
    SEC_GREY    = 3'd6
  } sector_t;

  // exact floor(y / 60) for y below 2^Y_W, saturated at 255
  function automatic chan_t div60_sat(input logic [Y_W-1:0] y);
    logic [29:0] prod;
    logic [8:0]  quo;
    prod = 30'(y) * 30'(RECIP_60);
    quo  = 9'(prod >> RECIP_SHIFT);
    return (quo > 9'd255) ? 8'd255 : quo[7:0];
  endfunction

endpackage

`default_nettype wire

### design/hsv_to_rgb_converter.sv
// hsv to rgb converter, eight-stage pipeline with valid/stall handshake
`default_nettype none

// Converts one hue/saturation/value word per clock, unless stalled, into
// 8-bit red, green and blue. Hue is degrees with HUE_FRAC_BITS fractional
// bits; hue of 360 or more gives grey. Saturation and brightness use
// 2^UNIT_FRAC_BITS for 1.0 and are clamped there. Throughput is one word
// per cycle while out_stall is low. Each stage holds its word only while the
// stage after it is full and stalled, so in_stall follows out_stall through
// the chain of stage valids. The longest stage path is the secondary-channel
// multiply (vs * fraction) in stage four.
module hsv_to_rgb_converter #(
  parameter int HUE_FRAC_BITS  = 6,
  parameter int UNIT_FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [14:0] in_hue,
  input  wire logic [8:0]  in_saturation,
  input  wire logic [8:0]  in_brightness,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);

  localparam int NSTG     = 8;
  localparam int UNIT_ONE = 1 << UNIT_FRAC_BITS;
  localparam int SPAN     = 60 << HUE_FRAC_BITS;
  localparam int HB       = HUE_FRAC_BITS + 6;
  localparam int TW       = (HUE_FRAC_BITS + 9 > 15) ? HUE_FRAC_BITS + 9 : 15;
  localparam int PW       = UNIT_FRAC_BITS + 9;
  localparam int NW       = PW + HB;
  localparam int SH_N     = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS;
  localparam int YW       = hsv2rgb_pkg::Y_W;

  // stage valids and advance chain
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // stage 1: clamp, sector search, fraction within sector
  logic [TW-1:0]        hue_w;
  logic [TW-1:0]        base_w;
  logic [8:0]           sat1_nxt, val1_nxt;
  hsv2rgb_pkg::sector_t sec1_nxt;
  logic [HB-1:0]        frac1_nxt;

  always_comb begin
    hue_w    = TW'(in_hue);
    sat1_nxt = (int'(in_saturation) > UNIT_ONE) ? 9'(UNIT_ONE) : in_saturation;
    val1_nxt = (int'(in_brightness) > UNIT_ONE) ? 9'(UNIT_ONE) : in_brightness;
    if (hue_w >= TW'(6 * SPAN)) begin
      sec1_nxt = hsv2rgb_pkg::SEC_GREY;
      base_w   = TW'(6 * SPAN);
    end else if (hue_w >= TW'(5 * SPAN)) begin
      sec1_nxt = hsv2rgb_pkg::SEC_MAG_RED;
      base_w   = TW'(5 * SPAN);
    end else if (hue_w >= TW'(4 * SPAN)) begin
      sec1_nxt = hsv2rgb_pkg::SEC_BLU_MAG;
      base_w   = TW'(4 * SPAN);
    end else if (hue_w >= TW'(3 * SPAN)) begin
      sec1_nxt = hsv2rgb_pkg::SEC_CYN_BLU;
      base_w   = TW'(3 * SPAN);
    end else if (hue_w >= TW'(2 * SPAN)) begin
      sec1_nxt = hsv2rgb_pkg::SEC_GRN_CYN;
      base_w   = TW'(2 * SPAN);
    end else if (hue_w >= TW'(SPAN)) begin
      sec1_nxt = hsv2rgb_pkg::SEC_YEL_GRN;
      base_w   = TW'(SPAN);
    end else begin
      sec1_nxt = hsv2rgb_pkg::SEC_RED_YEL;
      base_w   = '0;
    end
    frac1_nxt = HB'(hue_w - base_w);
  end

  logic [8:0]           sat1_r, val1_r;
  hsv2rgb_pkg::sector_t sec1_r;
  logic [HB-1:0]        frac1_r;

  // stage 2: chroma product and rising/falling fraction
  logic [17:0]   vs_full;
  logic [PW-1:0] vs2_nxt;
  logic [HB-1:0] x2_nxt;
  logic          odd1;

  always_comb begin
    vs_full = {9'd0, sat1_r} * {9'd0, val1_r};
    vs2_nxt = PW'(vs_full);
    odd1    = (sec1_r == hsv2rgb_pkg::SEC_YEL_GRN) ||
              (sec1_r == hsv2rgb_pkg::SEC_CYN_BLU) ||
              (sec1_r == hsv2rgb_pkg::SEC_MAG_RED);
    x2_nxt  = odd1 ? (HB'(SPAN) - frac1_r) : frac1_r;
  end

  logic [PW-1:0]        vs2_r;
  logic [8:0]           val2_r;
  logic [HB-1:0]        x2_r;
  hsv2rgb_pkg::sector_t sec2_r;

  // stage 3: v - c and the full-value (maximum) channel
  logic [PW-1:0]          mdiff3_nxt;
  logic [16:0]            cc_prod;
  hsv2rgb_pkg::chan_t     cc3_nxt;

  always_comb begin
    mdiff3_nxt = (PW'(val2_r) << UNIT_FRAC_BITS) - vs2_r;
    cc_prod    = (17'(val2_r) << 8) - 17'(val2_r);
    cc3_nxt    = 8'(cc_prod >> UNIT_FRAC_BITS);
  end

  logic [PW-1:0]        mdiff3_r, vs3_r;
  logic [HB-1:0]        x3_r;
  hsv2rgb_pkg::chan_t   cc3_r;
  hsv2rgb_pkg::sector_t sec3_r;

  // stage 4: secondary products and the minimum channel, also used for grey
  logic [NW-1:0]      a4_nxt, b4_nxt;
  logic [PW+7:0]      m_prod;
  hsv2rgb_pkg::chan_t mch4_nxt;

  always_comb begin
    a4_nxt   = NW'(vs3_r) * NW'(x3_r);
    b4_nxt   = NW'(mdiff3_r) * NW'(SPAN);
    m_prod   = ((PW+8)'(mdiff3_r) << 8) - (PW+8)'(mdiff3_r);
    mch4_nxt = 8'(m_prod >> (2 * UNIT_FRAC_BITS));
  end

  logic [NW-1:0]        a4_r, b4_r;
  hsv2rgb_pkg::chan_t   cc4_r, mch4_r;
  hsv2rgb_pkg::sector_t sec4_r;

  // stage 5: secondary numerator
  logic [NW-1:0]        n5_r;
  hsv2rgb_pkg::chan_t   cc5_r, mch5_r;
  hsv2rgb_pkg::sector_t sec5_r;

  // stage 6: scale by 255 and drop the power-of-two part of the denominator
  logic [NW+7:0]   n_prod;
  logic [YW-1:0]   y6_nxt;

  always_comb begin
    n_prod = ((NW+8)'(n5_r) << 8) - (NW+8)'(n5_r);
    y6_nxt = YW'(n_prod >> SH_N);
  end

  logic [YW-1:0]        y6_r;
  hsv2rgb_pkg::chan_t   cc6_r, mch6_r;
  hsv2rgb_pkg::sector_t sec6_r;

  // stage 7: divide by 60
  hsv2rgb_pkg::chan_t   sc7_r, cc7_r, mch7_r;
  hsv2rgb_pkg::sector_t sec7_r;

  // stage 8: channel routing
  hsv2rgb_pkg::chan_t red_nxt, green_nxt, blue_nxt;
  hsv2rgb_pkg::chan_t red_r, green_r, blue_r;

  always_comb begin
    red_nxt   = mch7_r;
    green_nxt = mch7_r;
    blue_nxt  = mch7_r;
    unique case (sec7_r)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_nxt   = cc7_r;
        green_nxt = sc7_r;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_nxt   = sc7_r;
        green_nxt = cc7_r;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        green_nxt = cc7_r;
        blue_nxt  = sc7_r;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        green_nxt = sc7_r;
        blue_nxt  = cc7_r;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_nxt  = sc7_r;
        blue_nxt = cc7_r;
      end
      hsv2rgb_pkg::SEC_MAG_RED: begin
        red_nxt  = cc7_r;
        blue_nxt = sc7_r;
      end
      hsv2rgb_pkg::SEC_GREY: begin
        red_nxt = mch7_r;
      end
      default: begin
        red_nxt = mch7_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sat1_r  <= sat1_nxt;
      val1_r  <= val1_nxt;
      sec1_r  <= sec1_nxt;
      frac1_r <= frac1_nxt;
    end
    if (adv[1]) begin
      vs2_r  <= vs2_nxt;
      val2_r <= val1_r;
      x2_r   <= x2_nxt;
      sec2_r <= sec1_r;
    end
    if (adv[2]) begin
      mdiff3_r <= mdiff3_nxt;
      vs3_r    <= vs2_r;
      x3_r     <= x2_r;
      cc3_r    <= cc3_nxt;
      sec3_r   <= sec2_r;
    end
    if (adv[3]) begin
      a4_r   <= a4_nxt;
      b4_r   <= b4_nxt;
      cc4_r  <= cc3_r;
      mch4_r <= mch4_nxt;
      sec4_r <= sec3_r;
    end
    if (adv[4]) begin
      n5_r   <= a4_r + b4_r;
      cc5_r  <= cc4_r;
      mch5_r <= mch4_r;
      sec5_r <= sec4_r;
    end
    if (adv[5]) begin
      y6_r   <= y6_nxt;
      cc6_r  <= cc5_r;
      mch6_r <= mch5_r;
      sec6_r <= sec5_r;
    end
    if (adv[6]) begin
      sc7_r  <= hsv2rgb_pkg::div60_sat(y6_r);
      cc7_r  <= cc6_r;
      mch7_r <= mch6_r;
      sec7_r <= sec6_r;
    end
    if (adv[7]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

`default_nettype wire
